// ===== design/bounded_key_set_register_query_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bounded key set query core
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_KEY_SET_REGISTER_QUERY_CORE_DEFINES_SVH
`define BOUNDED_KEY_SET_REGISTER_QUERY_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BKSRQ_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("bksrq assertion failed");
// next-cycle implication
`define BKSRQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("bksrq assertion failed");
`else
`define BKSRQ_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define BKSRQ_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ===== design/bksrq_pkg.sv =====
// ---------------------------------------------------------------------------
// bksrq_pkg
// Types and constants shared by the bounded key set query core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bksrq_pkg;

   localparam int KEY_W        = 64;
   localparam int CAPACITY_DEF = 256;

   // action codes
   localparam logic ACT_REGISTER = 1'b0;
   localparam logic ACT_QUERY    = 1'b1;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] key;
   } req_payload_type;

   typedef struct packed {
      logic present;
      logic inserted;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic full;
   } dp_status_type;

endpackage

// ===== design/bksrq_ram.sv =====
// ---------------------------------------------------------------------------
// bksrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bksrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bksrq_dp.sv =====
// ---------------------------------------------------------------------------
// bksrq_dp
// Datapath: key store, fill count, scan pointer, compare and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bksrq_dp import bksrq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   input  req_payload_type req_data,
   output dp_status_type   status,
   output rsp_payload_type rsp_data
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             action_ff, action_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             found_ff, found_in;
   logic             rd_pend_ff, rd_pend_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             rd_en;
   logic [KEY_W-1:0] rd_data;
   logic             full;
   logic             do_insert;

   assign full      = (fill_ff == CAP_CNT);
   assign rd_en     = cmd.scan && (idx_ff != fill_ff);
   assign do_insert = cmd.finish && (action_ff == ACT_REGISTER) && !found_ff && !full;

   bksrq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (do_insert),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // latch item, advance scan, compare, append on finish
   always_comb begin
      key_in     = key_ff;
      action_in  = action_ff;
      idx_in     = idx_ff;
      fill_in    = fill_ff;
      found_in   = found_ff;
      rd_pend_in = 1'b0;
      rsp_in     = rsp_ff;
      if (cmd.load) begin
         key_in    = req_data.key;
         action_in = req_data.action;
         idx_in    = '0;
         found_in  = 1'b0;
      end else begin
         if (rd_pend_ff && (rd_data == key_ff)) begin
            found_in = 1'b1;
         end
         if (rd_en) begin
            idx_in     = idx_ff + CNT_W'(1);
            rd_pend_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         rsp_in.present  = found_ff;
         rsp_in.inserted = do_insert;
      end
      if (do_insert) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         rd_pend_ff <= 1'b0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         rd_pend_ff <= rd_pend_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      action_ff <= action_in;
      rsp_ff    <= rsp_in;
   end

   assign status.scan_done = (idx_ff == fill_ff) && !rd_pend_ff;
   assign status.full      = full;
   assign rsp_data         = rsp_ff;

endmodule

// ===== design/bksrq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bksrq_ctrl
// Controller: sequences accept, scan and finish, and owns the result valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bksrq_ctrl import bksrq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done && slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result beat until taken
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/bounded_key_set_register_query_core.sv =====
// ---------------------------------------------------------------------------
// bounded_key_set_register_query_core
// Fixed-capacity set of 64-bit keys with register and membership query.
//
// Request channel (req_valid/req_ready/req_data): one beat carries an action
// (register or query) and a key. Result channel (rsp_valid/rsp_ready/
// rsp_data): one beat per request with present (key was stored before this
// request) and inserted (a register request stored the key newly).
// Each request scans the stored keys one per cycle through the key store's
// single registered read port. The result is posted once the scan has read
// and compared every stored key, and a new request is accepted only after
// the previous request's result has been posted and the block is idle again.
// A register request that finds the key, or finds the set full, leaves the
// set unchanged. There is no removal.
// Reset clears the fill count, so the set starts empty; the key store needs
// no clearing pass. A result that waits in the output register does not block
// acceptance of the next request; if the receiver still holds off when that
// request's scan ends, the block waits before posting the new result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_key_set_register_query_core_defines.svh"

module bounded_key_set_register_query_core import bksrq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence control
   bksrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // key store and compare
   bksrq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // one request at a time: no accept right after an accept
   `BKSRQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   // a newly stored key cannot have been present
   `BKSRQ_ASSERT_IMPLY(a_ins_not_present, clock, reset, rsp_valid && rsp_data.inserted, !rsp_data.present)
   // the set never shrinks once full
   `BKSRQ_ASSERT_NEXT(a_full_sticky, clock, reset, status.full, status.full)
   // a result is posted only after a finished scan
   `BKSRQ_ASSERT_IMPLY(a_finish_done, clock, reset, cmd.finish, status.scan_done)

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded key set register/query core. A table
// of hand-picked requests runs first, then random register and query beats
// under three idle mixes. Each answer is checked against the row's hand-written
// answer where the script gives one, else against an in-bench copy of the key set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bksrq_pkg::*;

   localparam int SET_SIZE     = CAPACITY_DEF;
   localparam int RANDOM_BEATS = 500;
   localparam int HOLD_CYCLES  = 1500;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int SHOWN_FAULTS = 10;

   // one row of the directed script; known marks a hand-written answer
   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] key;
      logic             known;
      logic             present;
      logic             inserted;
   } script_row_type;

   localparam int SCRIPT_LEN = 18;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // empty set: nothing is present
      '{ACT_QUERY,    64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0},
      '{ACT_QUERY,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0},
      // first register, then a duplicate of it
      '{ACT_REGISTER, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b1},
      '{ACT_REGISTER, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
      '{ACT_QUERY,    64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
      '{ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1},
      '{ACT_QUERY,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0},
      // one bit away from a stored key
      '{ACT_QUERY,    64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 1'b0},
      '{ACT_REGISTER, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1},
      '{ACT_QUERY,    64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0},
      '{ACT_REGISTER, 64'h0000_0000_0000_0001, 1'b1, 1'b0, 1'b1},
      '{ACT_REGISTER, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b1},
      '{ACT_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b1},
      '{ACT_QUERY,    64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b0},
      '{ACT_REGISTER, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
      '{ACT_REGISTER, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,    64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,    64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 1'b0}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   // bench copy of the key set
   logic [KEY_W-1:0] held_keys [SET_SIZE];
   int unsigned      held_count;

   rsp_payload_type awaited_answers [$];
   rsp_payload_type oldest_answer;

   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned hold_requests;
   int unsigned hold_served;
   int unsigned fault_count;
   int unsigned answer_count;
   int unsigned cycle_count;

   bounded_key_set_register_query_core #(
      .CAPACITY (SET_SIZE)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // scan the set, append on a new register while there is room
   function automatic rsp_payload_type predict_membership(input req_payload_type beat);
      rsp_payload_type answer;
      logic            found;
      found = 1'b0;
      for (int i = 0; i < held_count; i++) begin
         if (held_keys[i] == beat.key) begin
            found = 1'b1;
         end
      end
      answer.present  = found;
      answer.inserted = 1'b0;
      if (beat.action == ACT_REGISTER && !found && held_count < SET_SIZE) begin
         held_keys[held_count] = beat.key;
         held_count++;
         answer.inserted = 1'b1;
      end
      return answer;
   endfunction

   // mostly new registrations, then hits, near misses and random queries
   function automatic req_payload_type draw_request();
      req_payload_type beat;
      int unsigned     pick;
      int unsigned     slot;
      pick        = $urandom_range(0, 99);
      beat.key    = {$urandom, $urandom};
      beat.action = $urandom_range(0, 1) ? ACT_QUERY : ACT_REGISTER;
      if (pick < 50 || held_count == 0) begin
         beat.action = ACT_REGISTER;
      end else if (pick < 80) begin
         slot     = $urandom_range(0, held_count - 1);
         beat.key = held_keys[slot];
      end else if (pick < 90) begin
         slot     = $urandom_range(0, held_count - 1);
         beat.key = held_keys[slot] ^ (64'h1 << $urandom_range(0, KEY_W - 1));
      end else begin
         beat.action = ACT_QUERY;
      end
      return beat;
   endfunction

   // offer one beat, hold it until accepted, then record its answer
   task automatic offer_request(input req_payload_type beat, input logic known,
                                input rsp_payload_type typed_answer);
      rsp_payload_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = predict_membership(beat);
      awaited_answers.push_back(known ? typed_answer : predicted);
   endtask

   // drop valid and wait for every outstanding answer
   task automatic drain_answers();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // receiver: random back-pressure, plus long hold-offs on request
   initial begin
      rsp_ready   = 1'b0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // check each result beat against the oldest expected answer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         answer_count++;
         if (awaited_answers.size() == 0) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS) begin
               $display("result beat %0d with no request pending: present=%0b inserted=%0b",
                        answer_count, rsp_data.present, rsp_data.inserted);
            end
         end else begin
            oldest_answer = awaited_answers.pop_front();
            if (rsp_data.present !== oldest_answer.present ||
                rsp_data.inserted !== oldest_answer.inserted) begin
               fault_count++;
               if (fault_count <= SHOWN_FAULTS) begin
                  $display("result beat %0d: expected present=%0b inserted=%0b, %s%0b %s%0b",
                           answer_count, oldest_answer.present, oldest_answer.inserted,
                           "got present=", rsp_data.present, "inserted=",
                           rsp_data.inserted);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, awaited_answers.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_payload_type beat;
      rsp_payload_type typed_answer;
      req_valid     = 1'b0;
      req_data      = '0;
      reset         = 1'b1;
      held_count    = 0;
      hold_requests = 0;
      fault_count   = 0;
      answer_count  = 0;
      cycle_count   = 0;
      req_idle_pct  = 22;
      rsp_idle_pct  = 73;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      foreach (SCRIPT[i]) begin
         beat.action           = SCRIPT[i].action;
         beat.key              = SCRIPT[i].key;
         typed_answer.present  = SCRIPT[i].present;
         typed_answer.inserted = SCRIPT[i].inserted;
         offer_request(beat, SCRIPT[i].known, typed_answer);
      end
      drain_answers();

      // random beats, sender light and receiver heavy idling
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         offer_request(draw_request(), 1'b0, '0);
      end
      drain_answers();

      // swap the idle mix
      req_idle_pct = 73;
      rsp_idle_pct = 22;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         offer_request(draw_request(), 1'b0, '0);
      end
      drain_answers();

      // no idling; stall the receiver so the core backs up its input
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 0 || n == RANDOM_BEATS / 2) begin
            hold_requests++;
         end
         offer_request(draw_request(), 1'b0, '0);
      end
      drain_answers();

      // let any stray result show up before the verdict
      repeat (SET_SIZE + 8) @(posedge clock);
      if (fault_count == 0 && awaited_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/bksrq_pkg.sv
design/bksrq_ram.sv
design/bksrq_dp.sv
design/bksrq_ctrl.sv
design/bounded_key_set_register_query_core.sv
tb/sv/tb.sv
